// ===== rtl/aavr_pkg.sv =====
// Shared types and constants for the axis-angle vector rotation core.
package aavr_pkg;

  localparam int Q14_ONE = 16384;

  localparam logic [2:0] REG_COS    = 3'd0;
  localparam logic [2:0] REG_SIN    = 3'd1;
  localparam logic [2:0] REG_AXIS_X = 3'd2;
  localparam logic [2:0] REG_AXIS_Y = 3'd3;
  localparam logic [2:0] REG_AXIS_Z = 3'd4;

  typedef logic signed [15:0] coord_t;
  typedef logic signed [33:0] entry_t;

  typedef struct packed {
    entry_t c0;
    entry_t c1;
    entry_t c2;
  } row_t;

  typedef struct packed {
    row_t r0;
    row_t r1;
    row_t r2;
  } matrix_t;

endpackage

// ===== rtl/aavr_matrix.sv =====
// Configuration registers and the pipelined axis-angle matrix builder.
module aavr_matrix (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [2:0]            cfg_index,
  input  logic [15:0]           cfg_data,
  output aavr_pkg::matrix_t     mat,
  output logic                  busy
);

  localparam logic [1:0] SETTLE = 2'd3;

  logic [15:0] cos_reg, sin_reg, ax_reg, ay_reg, az_reg;
  logic [1:0]  settle;

  logic signed [31:0] aa_xx, aa_yy, aa_zz, aa_xy, aa_xz, aa_yz;
  logic signed [31:0] sa_x1, sa_y1, sa_z1;
  logic signed [15:0] c1;
  logic signed [16:0] t1;

  logic signed [47:0] taa_xx, taa_yy, taa_zz, taa_xy, taa_xz, taa_yz;
  logic signed [47:0] cdiag2, sax2, say2, saz2;

  function automatic logic signed [47:0] mul48(logic signed [47:0] a, logic signed [47:0] b);
    return a * b;
  endfunction

  function automatic aavr_pkg::entry_t rnd14(logic signed [47:0] v);
    logic signed [47:0] r;
    r = v + 48'sd8192;
    return r[47:14];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      cos_reg <= 16'(aavr_pkg::Q14_ONE);
      sin_reg <= '0;
      ax_reg  <= '0;
      ay_reg  <= '0;
      az_reg  <= 16'(aavr_pkg::Q14_ONE);
      settle  <= SETTLE;
    end else if (cfg_write) begin
      settle <= SETTLE;
      case (cfg_index)
        aavr_pkg::REG_COS:    cos_reg <= cfg_data;
        aavr_pkg::REG_SIN:    sin_reg <= cfg_data;
        aavr_pkg::REG_AXIS_X: ax_reg  <= cfg_data;
        aavr_pkg::REG_AXIS_Y: ay_reg  <= cfg_data;
        aavr_pkg::REG_AXIS_Z: az_reg  <= cfg_data;
        default: ;
      endcase
    end else if (settle != 2'd0) begin
      settle <= settle - 2'd1;
    end
  end

  assign busy = (settle != 2'd0);

  // stage 1: axis products and sine terms
  always_ff @(posedge clk) begin
    aa_xx <= signed'(ax_reg) * signed'(ax_reg);
    aa_yy <= signed'(ay_reg) * signed'(ay_reg);
    aa_zz <= signed'(az_reg) * signed'(az_reg);
    aa_xy <= signed'(ax_reg) * signed'(ay_reg);
    aa_xz <= signed'(ax_reg) * signed'(az_reg);
    aa_yz <= signed'(ay_reg) * signed'(az_reg);
    sa_x1 <= signed'(sin_reg) * signed'(ax_reg);
    sa_y1 <= signed'(sin_reg) * signed'(ay_reg);
    sa_z1 <= signed'(sin_reg) * signed'(az_reg);
    c1    <= signed'(cos_reg);
    t1    <= 17'(aavr_pkg::Q14_ONE) - {cos_reg[15], cos_reg};
  end

  // stage 2: (1 - c) * a_i * a_j, cosine diagonal and sine terms, all at scale 2^42
  always_ff @(posedge clk) begin
    taa_xx <= mul48(48'(t1), 48'(aa_xx));
    taa_yy <= mul48(48'(t1), 48'(aa_yy));
    taa_zz <= mul48(48'(t1), 48'(aa_zz));
    taa_xy <= mul48(48'(t1), 48'(aa_xy));
    taa_xz <= mul48(48'(t1), 48'(aa_xz));
    taa_yz <= mul48(48'(t1), 48'(aa_yz));
    cdiag2 <= 48'(c1) <<< 28;
    sax2   <= 48'(sa_x1) <<< 14;
    say2   <= 48'(sa_y1) <<< 14;
    saz2   <= 48'(sa_z1) <<< 14;
  end

  // stage 3: entries rounded to scale 2^28
  always_ff @(posedge clk) begin
    mat.r0.c0 <= rnd14(taa_xx + cdiag2);
    mat.r0.c1 <= rnd14(taa_xy - saz2);
    mat.r0.c2 <= rnd14(taa_xz + say2);
    mat.r1.c0 <= rnd14(taa_xy + saz2);
    mat.r1.c1 <= rnd14(taa_yy + cdiag2);
    mat.r1.c2 <= rnd14(taa_yz - sax2);
    mat.r2.c0 <= rnd14(taa_xz - say2);
    mat.r2.c1 <= rnd14(taa_yz + sax2);
    mat.r2.c2 <= rnd14(taa_zz + cdiag2);
  end

endmodule

// ===== rtl/aavr_lane.sv =====
// One output lane: dot product of a matrix row with the point, rounded and saturated.
module aavr_lane (
  input  logic             clk,
  input  logic             en,
  input  aavr_pkg::row_t   row,
  input  aavr_pkg::coord_t p0,
  input  aavr_pkg::coord_t p1,
  input  aavr_pkg::coord_t p2,
  output aavr_pkg::coord_t res
);

  logic signed [49:0] e0, e1, e2, q0, q1, q2;
  logic signed [49:0] prod0, prod1, prod2;
  logic signed [51:0] sum, rnd;
  logic signed [23:0] q;

  always_comb begin
    e0 = 50'(signed'(row.c0));
    e1 = 50'(signed'(row.c1));
    e2 = 50'(signed'(row.c2));
    q0 = 50'(p0);
    q1 = 50'(p1);
    q2 = 50'(p2);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod0 <= e0 * q0;
      prod1 <= e1 * q1;
      prod2 <= e2 * q2;
    end
  end

  always_comb begin
    sum = 52'(prod0) + 52'(prod1) + 52'(prod2);
    rnd = sum + 52'sd134217728;
    q   = rnd[51:28];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (q > 24'sd32767) begin
        res <= 16'sh7fff;
      end else if (q < -24'sd32768) begin
        res <= 16'sh8000;
      end else begin
        res <= q[15:0];
      end
    end
  end

endmodule

// ===== rtl/aavr_merge.sv =====
// Merge stage: gathers the three lane results into one output beat, with a skid slot.
module aavr_merge (
  input  logic             clk,
  input  logic             rst,
  input  logic             take,
  input  aavr_pkg::coord_t lx,
  input  aavr_pkg::coord_t ly,
  input  aavr_pkg::coord_t lz,
  output logic             full,
  output logic             rot_valid,
  input  logic             rot_stall,
  output aavr_pkg::coord_t rot_x,
  output aavr_pkg::coord_t rot_y,
  output aavr_pkg::coord_t rot_z
);

  logic             skid_valid;
  aavr_pkg::coord_t sx, sy, sz;

  always_ff @(posedge clk) begin
    if (rst) begin
      rot_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (!rot_stall) begin
        rot_x      <= sx;
        rot_y      <= sy;
        rot_z      <= sz;
        skid_valid <= 1'b0;
      end
    end else if (take) begin
      if (rot_valid && rot_stall) begin
        sx         <= lx;
        sy         <= ly;
        sz         <= lz;
        skid_valid <= 1'b1;
      end else begin
        rot_x     <= lx;
        rot_y     <= ly;
        rot_z     <= lz;
        rot_valid <= 1'b1;
      end
    end else if (!rot_stall) begin
      rot_valid <= 1'b0;
    end
  end

  assign full = skid_valid;

endmodule

// ===== rtl/axis_angle_vector_rotation_core.sv =====
// Axis-angle rotation core: takes one point per cycle while the point channel is not
// stalled and returns the rotated point through the input register, lane multiply, lane
// round and saturate, and merge registers. The rate of one point per cycle is set by three
// lanes that each carry one matrix row. The matrix is rebuilt by a three-stage pipeline
// from the configuration registers; after reset and after every register write the
// point channel stalls while that pipeline settles.
module axis_angle_vector_rotation_core (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [2:0]            cfg_index,
  input  logic [15:0]           cfg_data,
  input  logic                  point_valid,
  output logic                  point_stall,
  input  logic signed [15:0]    point_x,
  input  logic signed [15:0]    point_y,
  input  logic signed [15:0]    point_z,
  output logic                  rot_valid,
  input  logic                  rot_stall,
  output logic signed [15:0]    rot_x,
  output logic signed [15:0]    rot_y,
  output logic signed [15:0]    rot_z
);

  aavr_pkg::matrix_t mat;
  aavr_pkg::coord_t  px, py, pz, lx, ly, lz;
  logic              busy, full, en, accept;
  logic              v0, v1, v2;

  aavr_matrix u_matrix (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .mat       (mat),
    .busy      (busy)
  );

  assign point_stall = full || busy;
  assign accept      = point_valid && !point_stall;
  assign en          = !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (en) begin
      v0 <= accept;
      v1 <= v0;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      px <= point_x;
      py <= point_y;
      pz <= point_z;
    end
  end

  aavr_lane u_lane_x (
    .clk (clk), .en (en), .row (mat.r0), .p0 (px), .p1 (py), .p2 (pz), .res (lx)
  );

  aavr_lane u_lane_y (
    .clk (clk), .en (en), .row (mat.r1), .p0 (px), .p1 (py), .p2 (pz), .res (ly)
  );

  aavr_lane u_lane_z (
    .clk (clk), .en (en), .row (mat.r2), .p0 (px), .p1 (py), .p2 (pz), .res (lz)
  );

  aavr_merge u_merge (
    .clk       (clk),
    .rst       (rst),
    .take      (v2 && en),
    .lx        (lx),
    .ly        (ly),
    .lz        (lz),
    .full      (full),
    .rot_valid (rot_valid),
    .rot_stall (rot_stall),
    .rot_x     (rot_x),
    .rot_y     (rot_y),
    .rot_z     (rot_z)
  );

endmodule

// ===== rtl/aavr_checker.sv =====
// Port-level checks for the rotation core, bound to the top level.
module aavr_checker (
  input logic        clk,
  input logic        rst,
  input logic        cfg_write,
  input logic        point_stall,
  input logic        rot_valid,
  input logic        rot_stall,
  input logic [15:0] rot_x,
  input logic [15:0] rot_y,
  input logic [15:0] rot_z
);

  a_reset_holds_points: assert property (@(posedge clk) rst |=> point_stall)
    else $error("point channel open right after reset");

  a_cfg_holds_points: assert property (@(posedge clk) cfg_write |=> point_stall)
    else $error("point beat taken while matrix rebuilds");

  a_cfg_settle: assert property (@(posedge clk) cfg_write |-> ##3 point_stall)
    else $error("point channel reopened before matrix settled");

  a_rot_hold: assert property (@(posedge clk) disable iff (rst)
    rot_valid && rot_stall |=> rot_valid && $stable(rot_x) && $stable(rot_y)
      && $stable(rot_z))
    else $error("stalled result beat changed");

endmodule

bind axis_angle_vector_rotation_core aavr_checker u_aavr_checker (
  .clk         (clk),
  .rst         (rst),
  .cfg_write   (cfg_write),
  .point_stall (point_stall),
  .rot_valid   (rot_valid),
  .rot_stall   (rot_stall),
  .rot_x       (rot_x),
  .rot_y       (rot_y),
  .rot_z       (rot_z)
);

// ===== test/tb_axis_angle_vector_rotation_core.sv =====
// Self-checking testbench for the axis-angle point rotation core.
module tb_axis_angle_vector_rotation_core;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    aavr_pkg::coord_t x;
    aavr_pkg::coord_t y;
    aavr_pkg::coord_t z;
  } point_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_write = 1'b0;
  logic [2:0]       cfg_index = '0;
  logic [15:0]      cfg_data = '0;
  logic             point_valid = 1'b0;
  logic             point_stall;
  aavr_pkg::coord_t point_x = '0;
  aavr_pkg::coord_t point_y = '0;
  aavr_pkg::coord_t point_z = '0;
  logic             rot_valid;
  logic             rot_stall = 1'b0;
  aavr_pkg::coord_t rot_x;
  aavr_pkg::coord_t rot_y;
  aavr_pkg::coord_t rot_z;

  // predictor copy of the rotation registers
  aavr_pkg::coord_t cos_q = aavr_pkg::coord_t'(aavr_pkg::Q14_ONE);
  aavr_pkg::coord_t sin_q = '0;
  aavr_pkg::coord_t axis_q [3] = '{'0, '0, aavr_pkg::coord_t'(aavr_pkg::Q14_ONE)};

  point_t point_queue [$];
  point_t expected_rot [$];
  int unsigned error_count = 0;

  bit point_fired = 1'b0;
  bit src_gaps_on = 1'b1;
  bit sink_gaps_on = 1'b1;
  bit hold_req = 1'b0;
  int gap_left = 0;
  int stall_left = 0;
  int hold_left = 0;

  axis_angle_vector_rotation_core dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .point_valid(point_valid), .point_stall(point_stall),
    .point_x(point_x), .point_y(point_y), .point_z(point_z),
    .rot_valid(rot_valid), .rot_stall(rot_stall),
    .rot_x(rot_x), .rot_y(rot_y), .rot_z(rot_z)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // floor((v + 2^(sh-1)) / 2^sh)
  function automatic longint round_half_up(longint v, int sh);
    return (v + (longint'(1) <<< (sh - 1))) >>> sh;
  endfunction

  function automatic aavr_pkg::coord_t clamp16(longint v);
    if (v > 32767) return aavr_pkg::coord_t'(32767);
    if (v < -32768) return aavr_pkg::coord_t'(-32768);
    return aavr_pkg::coord_t'(v);
  endfunction

  function automatic point_t rotate_point(point_t p);
    longint c, s, t, acc;
    longint ax [3];
    longint pv [3];
    longint m [3][3];
    aavr_pkg::coord_t res [3];
    c = longint'(cos_q);
    s = longint'(sin_q);
    t = aavr_pkg::Q14_ONE - c;
    for (int i = 0; i < 3; i++) ax[i] = longint'(axis_q[i]);
    pv[0] = longint'(p.x);
    pv[1] = longint'(p.y);
    pv[2] = longint'(p.z);
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) begin
        m[i][j] = t * ax[i] * ax[j];
        if (i == j) m[i][j] += c <<< 28;
      end
    m[0][1] -= ax[2] * s * aavr_pkg::Q14_ONE;
    m[1][0] += ax[2] * s * aavr_pkg::Q14_ONE;
    m[0][2] += ax[1] * s * aavr_pkg::Q14_ONE;
    m[2][0] -= ax[1] * s * aavr_pkg::Q14_ONE;
    m[1][2] -= ax[0] * s * aavr_pkg::Q14_ONE;
    m[2][1] += ax[0] * s * aavr_pkg::Q14_ONE;
    for (int i = 0; i < 3; i++) begin
      acc = 0;
      for (int j = 0; j < 3; j++) acc += round_half_up(m[i][j], 14) * pv[j];
      res[i] = clamp16(round_half_up(acc, 28));
    end
    return '{res[0], res[1], res[2]};
  endfunction

  function automatic int draw_idle(bit enabled);
    int r;
    if (!enabled) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic aavr_pkg::coord_t rand_coord();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return aavr_pkg::coord_t'($urandom);
    if (r < 8) return aavr_pkg::coord_t'(int'($urandom_range(0, 4096)) - 2048);
    case ($urandom_range(0, 4))
      0: return aavr_pkg::coord_t'(32767);
      1: return aavr_pkg::coord_t'(-32768);
      2: return aavr_pkg::coord_t'(1);
      3: return aavr_pkg::coord_t'(-1);
      default: return '0;
    endcase
  endfunction

  task automatic check_coord(input string field, input aavr_pkg::coord_t want,
                             input aavr_pkg::coord_t got);
    if (got !== want) begin
      error_count++;
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
    end
  endtask

  // beats are taken at the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if (point_valid && !point_stall) begin
        expected_rot.push_back(rotate_point('{point_x, point_y, point_z}));
        void'(point_queue.pop_front());
        point_fired = 1'b1;
      end
      if (rot_valid && !rot_stall) begin
        if (expected_rot.size() == 0) begin
          error_count++;
          $display("%0t: unexpected beat: expected none, actual (%0d, %0d, %0d)",
                   $time, rot_x, rot_y, rot_z);
        end else begin
          point_t want;
          want = expected_rot.pop_front();
          check_coord("rot_x", want.x, rot_x);
          check_coord("rot_y", want.y, rot_y);
          check_coord("rot_z", want.z, rot_z);
        end
      end
    end
  end

  always @(negedge clk) begin : drive_points
    logic nxt_valid;
    nxt_valid = point_valid;
    if (rst) begin
      nxt_valid = 1'b0;
    end else if (!point_valid || point_fired) begin
      if (point_fired) gap_left = draw_idle(src_gaps_on);
      point_fired = 1'b0;
      nxt_valid = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (point_queue.size() > 0) begin
        nxt_valid = 1'b1;
        point_x <= point_queue[0].x;
        point_y <= point_queue[0].y;
        point_z <= point_queue[0].z;
      end
    end
    point_valid <= nxt_valid;
  end

  always @(negedge clk) begin : drive_sink
    logic nxt_stall;
    nxt_stall = 1'b0;
    if (rst) begin
      nxt_stall = 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      nxt_stall = 1'b1;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_left = 79;
      nxt_stall = 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      nxt_stall = 1'b1;
    end else begin
      stall_left = draw_idle(sink_gaps_on);
      if (stall_left > 0) begin
        stall_left--;
        nxt_stall = 1'b1;
      end
    end
    rot_stall <= nxt_stall;
  end

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_write <= 1'b0;
    case (idx)
      aavr_pkg::REG_COS:    cos_q = aavr_pkg::coord_t'(val);
      aavr_pkg::REG_SIN:    sin_q = aavr_pkg::coord_t'(val);
      aavr_pkg::REG_AXIS_X: axis_q[0] = aavr_pkg::coord_t'(val);
      aavr_pkg::REG_AXIS_Y: axis_q[1] = aavr_pkg::coord_t'(val);
      aavr_pkg::REG_AXIS_Z: axis_q[2] = aavr_pkg::coord_t'(val);
      default: ;
    endcase
  endtask

  task automatic set_rotation(input aavr_pkg::coord_t c, input aavr_pkg::coord_t s,
                              input aavr_pkg::coord_t ax, input aavr_pkg::coord_t ay,
                              input aavr_pkg::coord_t az);
    write_reg(aavr_pkg::REG_COS, c);
    write_reg(aavr_pkg::REG_SIN, s);
    write_reg(aavr_pkg::REG_AXIS_X, ax);
    write_reg(aavr_pkg::REG_AXIS_Y, ay);
    write_reg(aavr_pkg::REG_AXIS_Z, az);
  endtask

  task automatic push_point(input aavr_pkg::coord_t x, input aavr_pkg::coord_t y,
                            input aavr_pkg::coord_t z);
    point_queue.push_back('{x, y, z});
  endtask

  task automatic push_corners();
    push_point(32767, 32767, 32767);
    push_point(-32768, -32768, -32768);
    push_point(32767, -32768, 0);
    push_point(-1, 1, -32768);
  endtask

  // wait for the block to go idle before touching registers
  task automatic settle();
    while (point_queue.size() != 0 || expected_rot.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  function automatic aavr_pkg::coord_t near_unit();
    return aavr_pkg::coord_t'(int'($urandom_range(0, 32768)) - 16384);
  endfunction

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // identity after reset
    push_corners();
    push_point(0, 0, 0);
    push_point(1, -1, 1);
    push_point(16'sh5555, 16'shAAAA, 16'sh5555);
    push_point(16'shAAAA, 16'sh5555, 16'shAAAA);
    for (int n = 0; n < 120; n++) push_point(rand_coord(), rand_coord(), rand_coord());
    settle();

    // quarter turn about z
    set_rotation(0, aavr_pkg::coord_t'(aavr_pkg::Q14_ONE), 0, 0,
                 aavr_pkg::coord_t'(aavr_pkg::Q14_ONE));
    push_corners();
    settle();

    // register extremes, non-unit axis, saturating results
    set_rotation(-32768, -32768, -32768, -32768, -32768);
    push_corners();
    settle();
    set_rotation(32767, 32767, 32767, 32767, 32767);
    push_corners();
    settle();

    // writes past the last register are dropped
    for (int k = int'(aavr_pkg::REG_AXIS_Z) + 1; k < 8; k++)
      write_reg(3'(k), 16'($urandom));
    push_point(100, -200, 300);
    push_point(-32768, 32767, -1);
    push_point(4095, 0, -4096);
    settle();

    for (int ph = 0; ph < 9; ph++) begin
      if ($urandom_range(0, 1))
        set_rotation(aavr_pkg::coord_t'($urandom), aavr_pkg::coord_t'($urandom),
                     aavr_pkg::coord_t'($urandom), aavr_pkg::coord_t'($urandom),
                     aavr_pkg::coord_t'($urandom));
      else
        set_rotation(near_unit(), near_unit(), near_unit(), near_unit(), near_unit());
      src_gaps_on = (ph != 2 && ph != 5);
      sink_gaps_on = (ph != 5);
      if (ph == 2) hold_req = 1'b1;
      for (int n = 0; n < 180; n++) push_point(rand_coord(), rand_coord(), rand_coord());
      settle();
    end

    if (error_count == 0)
      $display("tb_axis_angle_vector_rotation_core passed");
    else
      $display("tb_axis_angle_vector_rotation_core failed");
    $finish;
  end

  initial begin
    #2000000;
    $display("tb_axis_angle_vector_rotation_core failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/aavr_pkg.sv
rtl/aavr_matrix.sv
rtl/aavr_lane.sv
rtl/aavr_merge.sv
rtl/axis_angle_vector_rotation_core.sv
rtl/aavr_checker.sv
test/tb_axis_angle_vector_rotation_core.sv
